// ----- hdl/rate_monotonic_admission_table_unit_defines.svh -----
// ----------------------------------------------------------------------------
// rate monotonic admission table - assertion macros
// immediate-implication and next-cycle-implication checks on clk_i / rst_ni
// ----------------------------------------------------------------------------
`ifndef RATE_MONOTONIC_ADMISSION_TABLE_UNIT_DEFINES_SVH
`define RATE_MONOTONIC_ADMISSION_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define RMAT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rmat check failed");
`define RMAT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rmat check failed");
`else
`define RMAT_ASSERT_IMP(lbl, ante, cons)
`define RMAT_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- hdl/rmat_pkg.sv -----
// ----------------------------------------------------------------------------
// rmat_pkg
// shared types and codes of the rate monotonic admission table
// ----------------------------------------------------------------------------
package rmat_pkg;

  localparam logic [2:0] StAdmit   = 3'd0;
  localparam logic [2:0] StOver    = 3'd1;
  localparam logic [2:0] StFull    = 3'd2;
  localparam logic [2:0] StDeleted = 3'd3;
  localparam logic [2:0] StBadSlot = 3'd4;

  localparam logic [16:0] UtilOne    = 17'd65536;
  localparam logic [16:0] LimitReset = 17'd45875;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] period;
    logic [16:0] util;
  } entry_t;

  typedef struct packed {
    logic        start;
    logic [15:0] compute;
    logic [15:0] period;
  } div_req_t;

endpackage

// ----- hdl/rmat_div.sv -----
// ----------------------------------------------------------------------------
// rmat_div
// radix-2 restoring divider: floor(compute*65536/period), saturated to 1.0
// ----------------------------------------------------------------------------
module rmat_div
  import rmat_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  div_req_t    req_i,
  output logic        done_o,
  output logic [16:0] util_o
);

  logic        busy_q, busy_d;
  logic [4:0]  step_q, step_d;
  logic [31:0] quo_q, quo_d;
  logic [15:0] rem_q, rem_d;
  logic [15:0] per_q, per_d;
  logic        done_q, done_d;
  logic [16:0] util_q, util_d;
  logic [16:0] trial;
  logic [31:0] quo_n;

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    per_d  = per_q;
    done_d = 1'b0;
    util_d = util_q;
    trial  = {rem_q, quo_q[31]};
    quo_n  = {quo_q[30:0], 1'b0};
    if (req_i.start) begin
      if (req_i.period == 16'd0) begin
        util_d = UtilOne;
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
        step_d = 5'd0;
        quo_d  = {req_i.compute, 16'd0};
        rem_d  = 16'd0;
        per_d  = req_i.period;
      end
    end else if (busy_q) begin
      if (trial >= {1'b0, per_q}) begin
        rem_d = 16'(trial - {1'b0, per_q});
        quo_n[0] = 1'b1;
      end else begin
        rem_d = trial[15:0];
      end
      quo_d  = quo_n;
      step_d = step_q + 5'd1;
      if (step_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        if (quo_n[31:17] != 15'd0 || quo_n[16:0] > UtilOne) begin
          util_d = UtilOne;
        end else begin
          util_d = quo_n[16:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= 5'd0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    per_q  <= per_d;
    util_q <= util_d;
  end

  assign done_o = done_q;
  assign util_o = util_q;

endmodule

// ----- hdl/rate_monotonic_admission_table_unit.sv -----
// ----------------------------------------------------------------------------
// rate_monotonic_admission_table_unit
// add: divide, compare with util_limit, then emit. delete: subtract its util,
// move each later entry down (read, then write), then emit. emit: per result,
// one read port scans the table for the next shortest period; rejects emit
// one status-only result. results cannot be stalled; reset empties the table,
// zero sum and ids, util_limit to 45875; table memory itself is not cleared
// ----------------------------------------------------------------------------
`include "rate_monotonic_admission_table_unit_defines.svh"

module rate_monotonic_admission_table_unit
  import rmat_pkg::*;
#(
  parameter int TASK_SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        operation_i,
  input  logic [15:0] period_i,
  input  logic [15:0] compute_time_i,
  input  logic [3:0]  slot_i,
  output logic        strobe_o,
  output logic [2:0]  status_o,
  output logic        entry_valid_o,
  output logic [3:0]  task_slot_o,
  output logic [15:0] task_id_o,
  output logic [15:0] task_period_o,
  output logic [4:0]  priority_res_o,
  output logic [16:0] total_utilization_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CntW = $clog2(TASK_SLOTS + 1);
  localparam int IdxW = $clog2(TASK_SLOTS);
  localparam int CmpW = (CntW > 4) ? CntW : 4;
  localparam int SW   = (IdxW > 4) ? IdxW : 4;
  localparam int PW   = (CntW + 1 > 5) ? CntW + 1 : 5;

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SDiv  = 3'd1;
  localparam logic [2:0] SDsub = 3'd2;
  localparam logic [2:0] SMrd  = 3'd3;
  localparam logic [2:0] SMwr  = 3'd4;
  localparam logic [2:0] SScan = 3'd5;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [16:0]     sum_q, sum_d;
  logic [15:0]     next_id_q, next_id_d;
  logic [16:0]     limit_q;
  logic [15:0]     id_q, id_d;
  logic [15:0]     per_q, per_d;
  logic [2:0]      st_q, st_d;
  logic [IdxW-1:0] mv_q, mv_d;
  logic [CntW-1:0] scan_q, scan_d;
  logic            pend_q, pend_d;
  logic [IdxW-1:0] pidx_q, pidx_d;
  logic            bvld_q, bvld_d;
  logic [15:0]     bper_q, bper_d;
  logic [15:0]     bid_q, bid_d;
  logic [IdxW-1:0] bidx_q, bidx_d;
  logic            hlast_q, hlast_d;
  logic [15:0]     lper_q, lper_d;
  logic [IdxW-1:0] lidx_q, lidx_d;
  logic [CntW-1:0] k_q, k_d;

  logic            ov_q, ov_d;
  logic [2:0]      ost_q, ost_d;
  logic            oev_q, oev_d;
  logic [3:0]      oslot_q, oslot_d;
  logic [15:0]     oid_q, oid_d;
  logic [15:0]     oper_q, oper_d;
  logic [4:0]      opri_q, opri_d;
  logic            olast_q, olast_d;

  entry_t          mem_q [TASK_SLOTS];
  entry_t          rd_q;
  logic [IdxW-1:0] ra;
  logic            we;
  logic [IdxW-1:0] wa;
  entry_t          wd;

  div_req_t        dreq;
  logic            ddone;
  logic [16:0]     dutil;

  logic            accept;
  logic [17:0]     total;
  logic            after_last, better;
  logic [PW-1:0]   pri_w;
  logic [SW-1:0]   slot_w, bidx_w;
  logic            cfg_wr;

  assign accept = start && !busy;
  assign busy   = (state_q != SIdle);
  assign total  = {1'b0, sum_q} + {1'b0, dutil};
  assign slot_w = SW'(slot_i);
  assign bidx_w = SW'(bidx_q);
  assign pri_w  = PW'(count_q) - PW'(k_q) + PW'(1);
  assign after_last = !hlast_q || (rd_q.period > lper_q) ||
                      (rd_q.period == lper_q && pidx_q > lidx_q);
  assign better = !bvld_q || (rd_q.period < bper_q);

  rmat_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .done_o (ddone),
    .util_o (dutil)
  );

  always_comb begin
    state_d = state_q; count_d = count_q; sum_d = sum_q; next_id_d = next_id_q;
    id_d = id_q; per_d = per_q; st_d = st_q; mv_d = mv_q;
    scan_d = scan_q; pend_d = 1'b0; pidx_d = pidx_q;
    bvld_d = bvld_q; bper_d = bper_q; bid_d = bid_q; bidx_d = bidx_q;
    hlast_d = hlast_q; lper_d = lper_q; lidx_d = lidx_q; k_d = k_q;
    ov_d = 1'b0; ost_d = ost_q; oev_d = oev_q; oslot_d = oslot_q; oid_d = oid_q;
    oper_d = oper_q; opri_d = opri_q; olast_d = olast_q;
    ra = scan_q[IdxW-1:0];
    we = 1'b0; wa = mv_q; wd = rd_q;
    dreq.start = 1'b0; dreq.compute = compute_time_i; dreq.period = period_i;

    unique case (state_q)
      SIdle: begin
        if (accept) begin
          if (!operation_i) begin
            id_d = next_id_q;
            next_id_d = next_id_q + 16'd1;
            per_d = period_i;
            if (count_q == CntW'(TASK_SLOTS)) begin
              ov_d = 1'b1; ost_d = StFull; oev_d = 1'b0; oslot_d = 4'd0;
              oid_d = 16'd0; oper_d = 16'd0; opri_d = 5'd0; olast_d = 1'b1;
            end else begin
              dreq.start = 1'b1;
              state_d = SDiv;
            end
          end else if (CmpW'(slot_i) >= CmpW'(count_q)) begin
            ov_d = 1'b1; ost_d = StBadSlot; oev_d = 1'b0; oslot_d = 4'd0;
            oid_d = 16'd0; oper_d = 16'd0; opri_d = 5'd0; olast_d = 1'b1;
          end else begin
            ra = slot_w[IdxW-1:0];
            mv_d = slot_w[IdxW-1:0];
            state_d = SDsub;
          end
        end
      end
      SDiv: begin
        if (ddone) begin
          if (total < {1'b0, limit_q}) begin
            we = 1'b1;
            wa = count_q[IdxW-1:0];
            wd.id = id_q; wd.period = per_q; wd.util = dutil;
            count_d = count_q + CntW'(1);
            sum_d = total[16:0];
            st_d = StAdmit;
            scan_d = '0; bvld_d = 1'b0; hlast_d = 1'b0; k_d = '0;
            state_d = SScan;
          end else begin
            ov_d = 1'b1; ost_d = StOver; oev_d = 1'b0; oslot_d = 4'd0;
            oid_d = 16'd0; oper_d = 16'd0; opri_d = 5'd0; olast_d = 1'b1;
            state_d = SIdle;
          end
        end
      end
      SDsub: begin
        sum_d = (rd_q.util > sum_q) ? 17'd0 : 17'(sum_q - rd_q.util);
        state_d = SMrd;
      end
      SMrd: begin
        if (CntW'(mv_q) + CntW'(1) < count_q) begin
          ra = IdxW'(mv_q + IdxW'(1));
          state_d = SMwr;
        end else begin
          count_d = count_q - CntW'(1);
          st_d = StDeleted;
          scan_d = '0; bvld_d = 1'b0; hlast_d = 1'b0; k_d = '0;
          if (count_q == CntW'(1)) begin
            ov_d = 1'b1; ost_d = StDeleted; oev_d = 1'b0; oslot_d = 4'd0;
            oid_d = 16'd0; oper_d = 16'd0; opri_d = 5'd0; olast_d = 1'b1;
            state_d = SIdle;
          end else begin
            state_d = SScan;
          end
        end
      end
      SMwr: begin
        we = 1'b1;
        wa = mv_q;
        wd = rd_q;
        mv_d = mv_q + IdxW'(1);
        state_d = SMrd;
      end
      SScan: begin
        if (scan_q < count_q) begin
          scan_d = scan_q + CntW'(1);
          pend_d = 1'b1;
          pidx_d = scan_q[IdxW-1:0];
        end
        if (pend_q && after_last && better) begin
          bvld_d = 1'b1;
          bper_d = rd_q.period;
          bid_d = rd_q.id;
          bidx_d = pidx_q;
        end
        if (scan_q == count_q && !pend_q) begin
          ov_d = 1'b1; ost_d = st_q; oev_d = 1'b1; oslot_d = bidx_w[3:0];
          oid_d = bid_q; oper_d = bper_q; opri_d = pri_w[4:0];
          olast_d = (k_q + CntW'(1) == count_q);
          hlast_d = 1'b1; lper_d = bper_q; lidx_d = bidx_q;
          k_d = k_q + CntW'(1);
          scan_d = '0; bvld_d = 1'b0;
          if (k_q + CntW'(1) == count_q) begin
            state_d = SIdle;
          end
        end
      end
      default: state_d = SIdle;
    endcase
  end

  assign cfg_wr = psel && penable && pwrite && pready && (paddr == 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      count_q   <= '0;
      sum_q     <= 17'd0;
      next_id_q <= 16'd0;
      limit_q   <= LimitReset;
      pend_q    <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      sum_q     <= sum_d;
      next_id_q <= next_id_d;
      pend_q    <= pend_d;
      ov_q      <= ov_d;
      if (cfg_wr) begin
        limit_q <= pwdata[16:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d; per_q <= per_d; st_q <= st_d; mv_q <= mv_d;
    scan_q <= scan_d; pidx_q <= pidx_d;
    bvld_q <= bvld_d; bper_q <= bper_d; bid_q <= bid_d; bidx_q <= bidx_d;
    hlast_q <= hlast_d; lper_q <= lper_d; lidx_q <= lidx_d; k_q <= k_d;
    ost_q <= ost_d; oev_q <= oev_d; oslot_q <= oslot_d; oid_q <= oid_d;
    oper_q <= oper_d; opri_q <= opri_d; olast_q <= olast_d;
  end

  // task table memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    rd_q <= mem_q[ra];
  end

  logic [16:0] tot_q;
  always_ff @(posedge clk_i) begin
    tot_q <= sum_d;
  end

  assign strobe_o            = ov_q;
  assign status_o            = ost_q;
  assign entry_valid_o       = oev_q;
  assign task_slot_o         = oslot_q;
  assign task_id_o           = oid_q;
  assign task_period_o       = oper_q;
  assign priority_res_o      = opri_q;
  assign total_utilization_o = tot_q;
  assign last_o              = olast_q;
  assign pready              = 1'b1;
  assign prdata              = (paddr == 3'd0) ? {15'd0, limit_q} : 32'd0;

  `RMAT_ASSERT_IMP(a_status_only_last, strobe_o && !entry_valid_o, last_o)
  `RMAT_ASSERT_IMP(a_count_range, 1'b1, count_q <= CntW'(TASK_SLOTS))
  `RMAT_ASSERT_NXT(a_accept_busy, accept && !operation_i && (count_q != CntW'(TASK_SLOTS)), busy)
  `RMAT_ASSERT_IMP(a_entry_status, strobe_o && entry_valid_o,
                   status_o == StAdmit || status_o == StDeleted)

endmodule
